[design/gdi_pkg.sv]
// shared constants, types and month tables for the gregorian date block
`default_nettype none

package gdi_pkg;

  localparam int YEAR_BITS_DEF = 14;
  localparam int MONTH_W       = 4;
  localparam int DAY_W         = 5;
  localparam int DOW_W         = 3;
  localparam int DOY_W         = 9;

  // floor(y / 100) == (y * DIV100_MUL) >> DIV100_SHIFT for any y below 2**16
  localparam int              MUL_W        = 17;
  localparam logic [MUL_W-1:0] DIV100_MUL  = 17'd83887;
  localparam int              DIV100_SHIFT = 23;

  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [DOW_W-1:0]   dow_t;
  typedef logic [DOY_W-1:0]   doy_t;

  localparam month_t MON_JAN = 4'd1;
  localparam month_t MON_FEB = 4'd2;
  localparam month_t MON_MAR = 4'd3;
  localparam month_t MON_APR = 4'd4;
  localparam month_t MON_MAY = 4'd5;
  localparam month_t MON_JUN = 4'd6;
  localparam month_t MON_JUL = 4'd7;
  localparam month_t MON_AUG = 4'd8;
  localparam month_t MON_SEP = 4'd9;
  localparam month_t MON_OCT = 4'd10;
  localparam month_t MON_NOV = 4'd11;
  localparam month_t MON_DEC = 4'd12;

  localparam dow_t DOW_SUN = 3'd0;
  localparam dow_t DOW_SAT = 3'd6;

  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    case (m) inside
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: len = 5'd31;
      MON_APR, MON_JUN, MON_SEP, MON_NOV:                           len = 5'd30;
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic doy_t days_before(input month_t m);
    doy_t n;
    case (m)
      MON_JAN: n = 9'd0;
      MON_FEB: n = 9'd31;
      MON_MAR: n = 9'd59;
      MON_APR: n = 9'd90;
      MON_MAY: n = 9'd120;
      MON_JUN: n = 9'd151;
      MON_JUL: n = 9'd181;
      MON_AUG: n = 9'd212;
      MON_SEP: n = 9'd243;
      MON_OCT: n = 9'd273;
      MON_NOV: n = 9'd304;
      MON_DEC: n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // floor(31 * mm / 12) with mm counted from march
  function automatic logic [4:0] wday_offset(input month_t m);
    logic [4:0] n;
    case (m)
      MON_JAN: n = 5'd28;
      MON_FEB: n = 5'd31;
      MON_MAR: n = 5'd2;
      MON_APR: n = 5'd5;
      MON_MAY: n = 5'd7;
      MON_JUN: n = 5'd10;
      MON_JUL: n = 5'd12;
      MON_AUG: n = 5'd15;
      MON_SEP: n = 5'd18;
      MON_OCT: n = 5'd20;
      MON_NOV: n = 5'd23;
      MON_DEC: n = 5'd25;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[design/gdi_in_if.sv]
// input date channel: year, month, day with valid/ready
`default_nettype none

interface gdi_in_if #(
  parameter int YEAR_BITS = gdi_pkg::YEAR_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [YEAR_BITS-1:0]   year;
  gdi_pkg::month_t        month;
  gdi_pkg::day_t          day;

  modport source (output valid, year, month, day, input ready);
  modport sink   (input valid, year, month, day, output ready);
endinterface

`default_nettype wire

[design/gdi_out_if.sv]
// result channel: validity, calendar facts and neighbouring dates
`default_nettype none

interface gdi_out_if #(
  parameter int YEAR_BITS = gdi_pkg::YEAR_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 valid_res;
  logic                 leap;
  gdi_pkg::day_t        days_in_month;
  gdi_pkg::dow_t        day_of_week;
  gdi_pkg::doy_t        day_of_year;
  logic                 weekend;
  logic [YEAR_BITS-1:0] next_year;
  gdi_pkg::month_t      next_month;
  gdi_pkg::day_t        next_day;
  logic [YEAR_BITS-1:0] prev_year;
  gdi_pkg::month_t      prev_month;
  gdi_pkg::day_t        prev_day;

  modport source (output valid, valid_res, leap, days_in_month, day_of_week, day_of_year,
                  weekend, next_year, next_month, next_day, prev_year, prev_month,
                  prev_day, input ready);
  modport sink   (input valid, valid_res, leap, days_in_month, day_of_week, day_of_year,
                  weekend, next_year, next_month, next_day, prev_year, prev_month,
                  prev_day, output ready);
endinterface

`default_nettype wire

[design/gdi_cent.sv]
// century split by reciprocal multiply, leap year, month length and validity
`default_nettype none

module gdi_cent #(
  parameter int YEAR_BITS = gdi_pkg::YEAR_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   adv,
  input  wire logic [YEAR_BITS-1:0]   year,
  input  wire gdi_pkg::month_t        month,
  input  wire gdi_pkg::day_t          day,
  output logic      [YEAR_BITS-1:0]   year_c,
  output gdi_pkg::month_t             month_c,
  output gdi_pkg::day_t               day_c,
  output logic                        leap_c,
  output gdi_pkg::day_t               dim_c,
  output logic                        ok_c,
  output logic                        early_c,
  output logic      [YEAR_BITS-7:0]   cent_c
);
  import gdi_pkg::*;

  localparam int QW = YEAR_BITS - 6;
  localparam int PW = YEAR_BITS + MUL_W;

  logic [PW-1:0]        prod;
  logic [QW-1:0]        q_b_r;
  logic [YEAR_BITS-1:0] year_b_r;
  month_t               month_b_r;
  day_t                 day_b_r;

  logic [YEAR_BITS-1:0] hund;
  logic                 whole_cent;
  logic                 leap_nxt;
  logic                 early_nxt;
  day_t                 dim_nxt;
  logic                 ok_nxt;
  logic [QW-1:0]        cent_nxt;

  logic [YEAR_BITS-1:0] year_c_r;
  month_t               month_c_r;
  day_t                 day_c_r;
  logic                 leap_c_r;
  day_t                 dim_c_r;
  logic                 ok_c_r;
  logic                 early_c_r;
  logic [QW-1:0]        cent_c_r;

  assign prod = PW'(year) * PW'(DIV100_MUL);

  always_ff @(posedge clk) begin
    if (adv) begin
      q_b_r     <= prod[DIV100_SHIFT +: QW];
      year_b_r  <= year;
      month_b_r <= month;
      day_b_r   <= day;
    end
  end

  always_comb begin
    // q * 100 as shifts and adds
    hund       = YEAR_BITS'({q_b_r, 6'b0}) + YEAR_BITS'({q_b_r, 5'b0})
               + YEAR_BITS'({q_b_r, 2'b0});
    whole_cent = (year_b_r == hund);
    leap_nxt   = (year_b_r[1:0] == 2'b00) && (!whole_cent || (q_b_r[1:0] == 2'b00));
    dim_nxt    = month_len(month_b_r, leap_nxt);
    ok_nxt     = (year_b_r != '0) && (day_b_r != '0) && (day_b_r <= dim_nxt);
    // january and february count with the year before
    early_nxt  = (month_b_r == MON_JAN) || (month_b_r == MON_FEB);
    cent_nxt   = q_b_r - QW'(early_nxt && whole_cent);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      year_c_r  <= year_b_r;
      month_c_r <= month_b_r;
      day_c_r   <= day_b_r;
      leap_c_r  <= leap_nxt;
      dim_c_r   <= dim_nxt;
      ok_c_r    <= ok_nxt;
      early_c_r <= early_nxt;
      cent_c_r  <= cent_nxt;
    end
  end

  assign year_c  = year_c_r;
  assign month_c = month_c_r;
  assign day_c   = day_c_r;
  assign leap_c  = leap_c_r;
  assign dim_c   = dim_c_r;
  assign ok_c    = ok_c_r;
  assign early_c = early_c_r;
  assign cent_c  = cent_c_r;

endmodule

`default_nettype wire

[design/gdi_date.sv]
// day of year, next and previous dates, and the raw weekday sum
`default_nettype none

module gdi_date #(
  parameter int YEAR_BITS = gdi_pkg::YEAR_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   adv,
  input  wire logic [YEAR_BITS-1:0]   year_c,
  input  wire gdi_pkg::month_t        month_c,
  input  wire gdi_pkg::day_t          day_c,
  input  wire logic                   leap_c,
  input  wire gdi_pkg::day_t          dim_c,
  input  wire logic                   ok_c,
  input  wire logic                   early_c,
  input  wire logic [YEAR_BITS-7:0]   cent_c,
  output logic      [YEAR_BITS+2:0]   sum_d,
  output logic                        ok_d,
  output logic                        leap_d,
  output gdi_pkg::day_t               dim_d,
  output gdi_pkg::doy_t               doy_d,
  output logic      [YEAR_BITS-1:0]   ny_d,
  output gdi_pkg::month_t             nm_d,
  output gdi_pkg::day_t               nd_d,
  output logic      [YEAR_BITS-1:0]   py_d,
  output gdi_pkg::month_t             pm_d,
  output gdi_pkg::day_t               pd_d
);
  import gdi_pkg::*;

  localparam int SW = YEAR_BITS + 3;
  localparam int QW = YEAR_BITS - 6;

  logic [YEAR_BITS-1:0] yy;
  logic [SW-1:0]        sum_nxt;
  doy_t                 doy_nxt;
  logic                 last_day;
  logic                 first_day;
  logic [YEAR_BITS-1:0] ny_nxt;
  month_t               nm_nxt;
  day_t                 nd_nxt;
  logic [YEAR_BITS-1:0] py_nxt;
  month_t               pm_nxt;
  day_t                 pd_nxt;

  logic [SW-1:0]        sum_d_r;
  logic                 ok_d_r;
  logic                 leap_d_r;
  day_t                 dim_d_r;
  doy_t                 doy_d_r;
  logic [YEAR_BITS-1:0] ny_d_r;
  month_t               nm_d_r;
  day_t                 nd_d_r;
  logic [YEAR_BITS-1:0] py_d_r;
  month_t               pm_d_r;
  day_t                 pd_d_r;

  always_comb begin
    yy      = year_c - YEAR_BITS'(early_c);
    sum_nxt = SW'(yy) + SW'(yy >> 2) - SW'(cent_c) + SW'(cent_c >> 2)
            + SW'(day_c) + SW'(wday_offset(month_c));
    doy_nxt = days_before(month_c) + DOY_W'(day_c)
            + DOY_W'(leap_c && (month_c > MON_FEB));

    last_day = (day_c == dim_c);
    if (last_day) begin
      nd_nxt = 5'd1;
      nm_nxt = (month_c == MON_DEC) ? MON_JAN : month_c + 4'd1;
      ny_nxt = (month_c == MON_DEC) ? year_c + YEAR_BITS'(1) : year_c;
    end else begin
      nd_nxt = day_c + 5'd1;
      nm_nxt = month_c;
      ny_nxt = year_c;
    end

    first_day = (day_c == 5'd1);
    if (first_day) begin
      pm_nxt = (month_c == MON_JAN) ? MON_DEC : month_c - 4'd1;
      py_nxt = (month_c == MON_JAN) ? year_c - YEAR_BITS'(1) : year_c;
      // december is 31 long whatever the year, so this year's leap flag serves
      pd_nxt = month_len(pm_nxt, leap_c);
    end else begin
      pd_nxt = day_c - 5'd1;
      pm_nxt = month_c;
      py_nxt = year_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_d_r  <= sum_nxt;
      ok_d_r   <= ok_c;
      leap_d_r <= leap_c;
      dim_d_r  <= dim_c;
      doy_d_r  <= ok_c ? doy_nxt : '0;
      ny_d_r   <= ok_c ? ny_nxt  : '0;
      nm_d_r   <= ok_c ? nm_nxt  : '0;
      nd_d_r   <= ok_c ? nd_nxt  : '0;
      py_d_r   <= ok_c ? py_nxt  : '0;
      pm_d_r   <= ok_c ? pm_nxt  : '0;
      pd_d_r   <= ok_c ? pd_nxt  : '0;
    end
  end

  assign sum_d  = sum_d_r;
  assign ok_d   = ok_d_r;
  assign leap_d = leap_d_r;
  assign dim_d  = dim_d_r;
  assign doy_d  = doy_d_r;
  assign ny_d   = ny_d_r;
  assign nm_d   = nm_d_r;
  assign nd_d   = nd_d_r;
  assign py_d   = py_d_r;
  assign pm_d   = pm_d_r;
  assign pd_d   = pd_d_r;

endmodule

`default_nettype wire

[design/gdi_wday.sv]
// weekday by folding the sum modulo 7, and the result register
`default_nettype none

module gdi_wday #(
  parameter int YEAR_BITS = gdi_pkg::YEAR_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   adv,
  input  wire logic [YEAR_BITS+2:0]   sum_d,
  input  wire logic                   ok_d,
  output gdi_pkg::dow_t               dow_e,
  output logic                        weekend_e
);
  import gdi_pkg::*;

  localparam int SW = YEAR_BITS + 3;
  localparam int CH = (SW + 2) / 3;

  logic [CH*3-1:0] padded;
  logic [5:0]      fold1;
  logic [3:0]      fold2;
  logic [2:0]      fold3;
  dow_t            dow_nxt;
  logic            weekend_nxt;

  dow_t            dow_e_r;
  logic            weekend_e_r;

  // 8 is 1 modulo 7, so octal digits add up to the same residue
  always_comb begin
    padded = (CH*3)'(sum_d);
    fold1  = '0;
    for (int i = 0; i < CH; i++) begin
      fold1 = fold1 + 6'(padded[3*i +: 3]);
    end
    fold2       = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    fold3       = fold2[2:0] + 3'(fold2[3]);
    dow_nxt     = (!ok_d || (fold3 == 3'd7)) ? DOW_SUN : fold3;
    weekend_nxt = ok_d && ((dow_nxt == DOW_SUN) || (dow_nxt == DOW_SAT));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dow_e_r     <= dow_nxt;
      weekend_e_r <= weekend_nxt;
    end
  end

  assign dow_e     = dow_e_r;
  assign weekend_e = weekend_e_r;

endmodule

`default_nettype wire

[design/gregorian_date_info.sv]
// top level: date calendar facts, one date per cycle through a short pipeline
//
//  channel  | dir | beat carries
//  ---------+-----+-----------------------------------------------------------
//  in_ch    | in  | year, month, day
//  out_ch   | out | valid_res, leap, days_in_month, day_of_week, day_of_year,
//           |     | weekend, next/prev year, month and day
//
// one beat in per cycle, one beat out per cycle while results are taken; each date
// passes the input register, the /100 reciprocal multiply stage, the leap and
// month length stage, and the weekday sum and modulo-7 fold stages
// all stages move together: a stalled result holds the whole pipe, and in_ch
// is ready whenever the result register is empty or being taken
// reset clears the stage valid bits only
`default_nettype none

module gregorian_date_info #(
  parameter int YEAR_BITS = gdi_pkg::YEAR_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  gdi_in_if.sink    in_ch,
  gdi_out_if.source out_ch
);
  import gdi_pkg::*;

  logic                 adv;
  logic [4:0]           vld_r;
  logic [4:0]           vld_nxt;

  logic [YEAR_BITS-1:0] year_a_r;
  month_t               month_a_r;
  day_t                 day_a_r;

  logic [YEAR_BITS-1:0] year_c;
  month_t               month_c;
  day_t                 day_c;
  logic                 leap_c;
  day_t                 dim_c;
  logic                 ok_c;
  logic                 early_c;
  logic [YEAR_BITS-7:0] cent_c;

  logic [YEAR_BITS+2:0] sum_d;
  logic                 ok_d;
  logic                 leap_d;
  day_t                 dim_d;
  doy_t                 doy_d;
  logic [YEAR_BITS-1:0] ny_d;
  month_t               nm_d;
  day_t                 nd_d;
  logic [YEAR_BITS-1:0] py_d;
  month_t               pm_d;
  day_t                 pd_d;

  dow_t                 dow_e;
  logic                 weekend_e;

  logic                 ok_e_r;
  logic                 leap_e_r;
  day_t                 dim_e_r;
  doy_t                 doy_e_r;
  logic [YEAR_BITS-1:0] ny_e_r;
  month_t               nm_e_r;
  day_t                 nd_e_r;
  logic [YEAR_BITS-1:0] py_e_r;
  month_t               pm_e_r;
  day_t                 pd_e_r;

  assign adv         = !vld_r[4] || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = {vld_r[3:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      year_a_r  <= in_ch.year;
      month_a_r <= in_ch.month;
      day_a_r   <= in_ch.day;
    end
  end

  gdi_cent #(.YEAR_BITS(YEAR_BITS)) u_cent (
    .clk     (clk),
    .adv     (adv),
    .year    (year_a_r),
    .month   (month_a_r),
    .day     (day_a_r),
    .year_c  (year_c),
    .month_c (month_c),
    .day_c   (day_c),
    .leap_c  (leap_c),
    .dim_c   (dim_c),
    .ok_c    (ok_c),
    .early_c (early_c),
    .cent_c  (cent_c)
  );

  gdi_date #(.YEAR_BITS(YEAR_BITS)) u_date (
    .clk     (clk),
    .adv     (adv),
    .year_c  (year_c),
    .month_c (month_c),
    .day_c   (day_c),
    .leap_c  (leap_c),
    .dim_c   (dim_c),
    .ok_c    (ok_c),
    .early_c (early_c),
    .cent_c  (cent_c),
    .sum_d   (sum_d),
    .ok_d    (ok_d),
    .leap_d  (leap_d),
    .dim_d   (dim_d),
    .doy_d   (doy_d),
    .ny_d    (ny_d),
    .nm_d    (nm_d),
    .nd_d    (nd_d),
    .py_d    (py_d),
    .pm_d    (pm_d),
    .pd_d    (pd_d)
  );

  gdi_wday #(.YEAR_BITS(YEAR_BITS)) u_wday (
    .clk       (clk),
    .adv       (adv),
    .sum_d     (sum_d),
    .ok_d      (ok_d),
    .dow_e     (dow_e),
    .weekend_e (weekend_e)
  );

  // result register for the fields already final in the previous stage
  always_ff @(posedge clk) begin
    if (adv) begin
      ok_e_r   <= ok_d;
      leap_e_r <= leap_d;
      dim_e_r  <= dim_d;
      doy_e_r  <= doy_d;
      ny_e_r   <= ny_d;
      nm_e_r   <= nm_d;
      nd_e_r   <= nd_d;
      py_e_r   <= py_d;
      pm_e_r   <= pm_d;
      pd_e_r   <= pd_d;
    end
  end

  assign out_ch.valid         = vld_r[4];
  assign out_ch.valid_res     = ok_e_r;
  assign out_ch.leap          = leap_e_r;
  assign out_ch.days_in_month = dim_e_r;
  assign out_ch.day_of_week   = dow_e;
  assign out_ch.day_of_year   = doy_e_r;
  assign out_ch.weekend       = weekend_e;
  assign out_ch.next_year     = ny_e_r;
  assign out_ch.next_month    = nm_e_r;
  assign out_ch.next_day      = nd_e_r;
  assign out_ch.prev_year     = py_e_r;
  assign out_ch.prev_month    = pm_e_r;
  assign out_ch.prev_day      = pd_e_r;

endmodule

`default_nettype wire

[sim/gdi_date_checker.sv]
// date result checker: predicts calendar facts per accepted date and compares result beats
`timescale 1ns / 1ps

module gdi_date_checker #(
  parameter int YEAR_BITS = gdi_pkg::YEAR_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  gdi_in_if    in_ch,
  gdi_out_if   out_ch,
  output int   mismatches,
  output int   facts_pending
);
  import gdi_pkg::*;

  typedef struct {
    logic                 valid_res;
    logic                 leap;
    day_t                 days_in_month;
    dow_t                 day_of_week;
    doy_t                 day_of_year;
    logic                 weekend;
    logic [YEAR_BITS-1:0] next_year;
    month_t               next_month;
    day_t                 next_day;
    logic [YEAR_BITS-1:0] prev_year;
    month_t               prev_month;
    day_t                 prev_day;
  } date_facts_t;

  date_facts_t facts_due[$];

  function automatic bit is_leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_of_month(input int unsigned y, input int unsigned m);
    case (m)
      MON_FEB: return is_leap_year(y) ? 29 : 28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: return 31;
      default: return 0;
    endcase
  endfunction

  function automatic date_facts_t date_facts(input int unsigned y, input int unsigned m,
                                             input int unsigned d);
    date_facts_t f;
    int unsigned len, a, yy, mm, wd, doy, py, pm;
    len = days_of_month(y, m);
    f = '{default: '0};
    f.leap          = is_leap_year(y);
    f.days_in_month = day_t'(len);
    f.valid_res     = (y >= 1) && (d >= 1) && (d <= len);
    if (f.valid_res) begin
      // march-based year: jan and feb belong to the year before
      a  = (14 - m) / 12;
      yy = y - a;
      mm = m + 12 * a - 2;
      wd = (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
      f.day_of_week = dow_t'(wd);
      f.weekend     = (wd == DOW_SUN) || (wd == DOW_SAT);
      doy = d;
      for (int unsigned k = MON_JAN; k < m; k++) doy += days_of_month(y, k);
      f.day_of_year = doy_t'(doy);
      if (d == len) begin
        f.next_day   = 1;
        f.next_month = (m == MON_DEC) ? MON_JAN : month_t'(m + 1);
        f.next_year  = (m == MON_DEC) ? YEAR_BITS'(y + 1) : YEAR_BITS'(y);
      end else begin
        f.next_day   = day_t'(d + 1);
        f.next_month = month_t'(m);
        f.next_year  = YEAR_BITS'(y);
      end
      if (d == 1) begin
        pm = (m == MON_JAN) ? MON_DEC : m - 1;
        py = (m == MON_JAN) ? y - 1 : y;
        f.prev_day = day_t'(days_of_month(py, pm));
      end else begin
        pm = m;
        py = y;
        f.prev_day = day_t'(d - 1);
      end
      f.prev_month = month_t'(pm);
      f.prev_year  = YEAR_BITS'(py);
    end
    return f;
  endfunction

  function automatic int field_differs(input string fld, input longint unsigned want,
                                       input longint unsigned got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    date_facts_t w;
    int bad;
    if (!rst_n) begin
      facts_due.delete();
      mismatches    <= 0;
      facts_pending <= 0;
    end else begin
      bad = 0;
      if (in_ch.valid && in_ch.ready)
        facts_due.push_back(date_facts(in_ch.year, in_ch.month, in_ch.day));
      if (out_ch.valid && out_ch.ready) begin
        if (facts_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual valid_res %0d",
                   $time, out_ch.valid_res);
          bad = 1;
        end else begin
          w = facts_due.pop_front();
          bad += field_differs("valid_res", w.valid_res, out_ch.valid_res);
          bad += field_differs("leap", w.leap, out_ch.leap);
          bad += field_differs("days_in_month", w.days_in_month, out_ch.days_in_month);
          bad += field_differs("day_of_week", w.day_of_week, out_ch.day_of_week);
          bad += field_differs("day_of_year", w.day_of_year, out_ch.day_of_year);
          bad += field_differs("weekend", w.weekend, out_ch.weekend);
          bad += field_differs("next_year", w.next_year, out_ch.next_year);
          bad += field_differs("next_month", w.next_month, out_ch.next_month);
          bad += field_differs("next_day", w.next_day, out_ch.next_day);
          bad += field_differs("prev_year", w.prev_year, out_ch.prev_year);
          bad += field_differs("prev_month", w.prev_month, out_ch.prev_month);
          bad += field_differs("prev_day", w.prev_day, out_ch.prev_day);
        end
      end
      mismatches    <= mismatches + bad;
      facts_pending <= facts_due.size();
    end
  end

endmodule

[sim/tb_gregorian_date_info.sv]
// testbench top: date stimulus with random idling, watchdog and verdict
`timescale 1ns / 1ps

module tb_gregorian_date_info;
  import gdi_pkg::*;

  localparam int YB         = YEAR_BITS_DEF;
  localparam int YEAR_TOP   = (1 << YB) - 1;
  localparam int RAND_DATES = 1300;
  localparam int CALM_DATES = 150;
  localparam int IDLE_LIMIT = 2000;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   facts_pending;
  int   in_idle_pct;
  int   out_idle_pct;
  int   stall_left;
  int   quiet_cycles;

  gdi_in_if  #(.YEAR_BITS(YB)) in_ch ();
  gdi_out_if #(.YEAR_BITS(YB)) out_ch ();

  gregorian_date_info #(.YEAR_BITS(YB)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gdi_date_checker #(.YEAR_BITS(YB)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatches    (mismatches),
    .facts_pending (facts_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left   <= 0;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(99) < out_idle_pct) begin
      stall_left   <= $urandom_range(0, 12);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_date(input int unsigned y, input int unsigned m, input int unsigned d);
    int gap;
    if ($urandom_range(99) < in_idle_pct) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.year  <= YB'(y);
    in_ch.month <= month_t'(m);
    in_ch.day   <= day_t'(d);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // mostly well-formed dates with random content, the rest noise and broken dates
  task automatic pick_date(output int unsigned y, output int unsigned m, output int unsigned d);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) begin
      case ($urandom_range(4))
        0, 1: y = $urandom_range(1, 9999);
        2: y = $urandom_range(1, YEAR_TOP);
        3: y = ($urandom_range(0, 1) ? 100 * $urandom_range(1, YEAR_TOP / 100)
                                     : 4 * $urandom_range(1, YEAR_TOP / 4));
        default: begin
          case ($urandom_range(5))
            0: y = 1;
            1: y = 2;
            2: y = YEAR_TOP;
            3: y = YEAR_TOP - 1;
            4: y = 9999;
            default: y = 10000;
          endcase
        end
      endcase
      m = $urandom_range(MON_JAN, MON_DEC);
      // month ends are where the rollover logic lives
      case ($urandom_range(3))
        0: d = 1;
        1: d = $urandom_range(28, 31);
        default: d = $urandom_range(1, 31);
      endcase
    end else if (sel < 85) begin
      y = $urandom_range(0, YEAR_TOP);
      m = $urandom_range(0, 15);
      d = $urandom_range(0, 31);
    end else begin
      y = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, YEAR_TOP);
      case ($urandom_range(2))
        0: begin
          m = ($urandom_range(1)) ? 0 : $urandom_range(13, 15);
          d = $urandom_range(0, 31);
        end
        1: begin
          m = $urandom_range(MON_JAN, MON_DEC);
          d = 0;
        end
        default: begin
          m = $urandom_range(MON_JAN, MON_DEC);
          d = $urandom_range(29, 31);
        end
      endcase
    end
  endtask

  initial begin
    int unsigned y, m, d;
    int pct_pick[3] = '{0, 10, 40};
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.year   <= '0;
    in_ch.month  <= '0;
    in_ch.day    <= '0;
    in_idle_pct  = 20;
    out_idle_pct = 20;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first day of the calendar: the day before falls in year zero
    send_date(1, MON_JAN, 1);
    send_date(YEAR_TOP, MON_DEC, 31);
    send_date(9999, MON_DEC, 31);
    // year zero is leap but never a valid date
    send_date(0, MON_JAN, 1);
    send_date(0, 0, 0);
    send_date(YEAR_TOP, 15, 31);
    send_date(2000, MON_FEB, 29);
    send_date(1900, MON_FEB, 29);
    send_date(1900, MON_FEB, 28);
    send_date(2024, MON_FEB, 29);
    send_date(2023, MON_FEB, 28);
    send_date(2024, MON_MAR, 1);
    send_date(2023, MON_MAR, 1);
    send_date(2024, 0, 1);
    send_date(2024, 13, 15);
    send_date(2024, MON_MAY, 0);
    send_date(2024, MON_APR, 31);
    send_date(2024, MON_APR, 30);
    send_date(2024, MON_DEC, 31);
    send_date(2023, MON_DEC, 31);
    send_date(2024, MON_JAN, 1);
    send_date(2022, MON_JAN, 1);
    send_date(2023, MON_JAN, 1);
    send_date(2024, MON_JUL, 31);
    send_date(2024, MON_AUG, 1);

    for (int i = 0; i < RAND_DATES; i++) begin
      if (i >= RAND_DATES - CALM_DATES) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else if (i % 100 == 0) begin
        in_idle_pct  = pct_pick[$urandom_range(2)];
        out_idle_pct = pct_pick[$urandom_range(2)];
      end
      pick_date(y, m, d);
      send_date(y, m, d);
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (facts_pending != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
